// ===== src/sfr_pkg.sv =====
package sfr_pkg;

  // Counter width of the good and bad frame counters (8 to 32)
  localparam int unsigned CountWidth = 32;

  // Operand widths of the tick divider
  localparam int unsigned DvdWidth  = 18;
  localparam int unsigned DivWidth  = 9;
  localparam int unsigned QuotWidth = 16;

  // Pulse limits in ticks
  localparam logic [QuotWidth-1:0] SyncMin   = 16'd55;
  localparam logic [QuotWidth-1:0] SyncMax   = 16'd57;
  localparam logic [QuotWidth-1:0] NibbleMin = 16'd12;
  localparam logic [QuotWidth-1:0] NibbleMax = 16'd27;

  // Pulse positions within a frame
  localparam logic [3:0] PulseSync   = 4'd0;
  localparam logic [3:0] PulseStatus = 4'd1;
  localparam logic [3:0] PulseData0  = 4'd2;
  localparam logic [3:0] PulseData5  = 4'd7;
  localparam logic [3:0] PulseCount  = 4'd9;

  localparam logic [3:0] Crc4Seed = 4'd5;
  localparam logic [5:0] Crc6Seed = 6'h15;

  localparam logic [7:0] TickReset = 8'd3;

  // Frame error codes
  localparam logic [2:0] ErrOk     = 3'd0;
  localparam logic [2:0] ErrShort  = 3'd1;
  localparam logic [2:0] ErrSync   = 3'd2;
  localparam logic [2:0] ErrNibble = 3'd3;
  localparam logic [2:0] ErrCrc    = 3'd4;

  // Serial message formats
  localparam logic [1:0] FmtShort = 2'd0;
  localparam logic [1:0] FmtEnh12 = 2'd1;
  localparam logic [1:0] FmtEnh16 = 2'd2;

  // Slow channel message detection masks
  localparam logic [15:0] ShortMark = 16'h8000;
  localparam logic [17:0] EnhMask   = 18'h3f800;
  localparam logic [17:0] EnhMark   = 18'h3f000;

  localparam logic [3:0] CRC4_TAB [16] = '{
    4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
    4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5};

  localparam logic [5:0] CRC6_TAB [64] = '{
    6'd0,  6'd25, 6'd50, 6'd43, 6'd61, 6'd36, 6'd15, 6'd22,
    6'd35, 6'd58, 6'd17, 6'd8,  6'd30, 6'd7,  6'd44, 6'd53,
    6'd31, 6'd6,  6'd45, 6'd52, 6'd34, 6'd59, 6'd16, 6'd9,
    6'd60, 6'd37, 6'd14, 6'd23, 6'd1,  6'd24, 6'd51, 6'd42,
    6'd62, 6'd39, 6'd12, 6'd21, 6'd3,  6'd26, 6'd49, 6'd40,
    6'd29, 6'd4,  6'd47, 6'd54, 6'd32, 6'd57, 6'd18, 6'd11,
    6'd33, 6'd56, 6'd19, 6'd10, 6'd28, 6'd5,  6'd46, 6'd55,
    6'd2,  6'd27, 6'd48, 6'd41, 6'd63, 6'd38, 6'd13, 6'd20};

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StFrame
  } sfr_state_e;

endpackage

// ===== src/sent_frame_receiver_unit.sv =====
// SENT frame receiver.
// Input channel: one item per measured pulse (period_us_i, frame_last_i),
// taken when in_valid_i is high and in_stall_o is low. in_stall_o is high
// while a pulse is being rounded to ticks or a frame result is being built.
// Output channel: one item per pulse flagged frame_last_i, held in an output
// register until out_valid_o is high and out_stall_i is low.
// Configuration: cfg_we_i writes cfg_data_i to the tick length register.
// A pulse is rounded before the next one is taken; after the last pulse of
// a frame the block also waits to load the frame result, which shows in
// the same cycle as the block can take the next pulse. Rounding is a
// radix-2 divider computing (2p+t)/(2t) one quotient bit per cycle (16 steps).
// A finished result may wait in the output register while the next frame
// is received; the block holds off only when a second result is ready and
// the first is still stalled.
// Reset clears the frame sequencer, slow channel shift registers, counters
// and sets the tick length to 3 us.
module sent_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] period_us_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_error_o,
  output logic [3:0]  status_nibble_o,
  output logic [23:0] data_nibbles_o,
  output logic        serial_valid_o,
  output logic [1:0]  serial_format_o,
  output logic [7:0]  serial_id_o,
  output logic [15:0] serial_data_o,
  output logic [31:0] good_frame_count_o,
  output logic [31:0] bad_frame_count_o
);
  import sfr_pkg::*;

  sfr_state_e state_q, state_d;

  logic [7:0]            tick_q;
  logic                  last_q;
  logic [3:0]            pidx_q, pidx_d;
  logic [2:0]            ferr_q, ferr_d;
  logic [3:0]            status_q, status_d;
  logic [23:0]           data_q, data_d;
  logic [3:0]            crc_q, crc_d;
  logic [3:0]            check_q, check_d;
  logic [17:0]           b2_q, b2_d;
  logic [17:0]           b3_q, b3_d;
  logic [23:0]           sc_q, sc_d;
  logic [CountWidth-1:0] good_q, good_d;
  logic [CountWidth-1:0] bad_q, bad_d;

  logic        ovalid_q, ovalid_d;
  logic [2:0]  oerr_q, oerr_d;
  logic [3:0]  ostat_q, ostat_d;
  logic [23:0] odata_q, odata_d;
  logic        osv_q, osv_d;
  logic [1:0]  ofmt_q, ofmt_d;
  logic [7:0]  oid_q, oid_d;
  logic [15:0] osdat_q, osdat_d;

  logic                  accept;
  logic                  div_start;
  logic                  div_done;
  logic [QuotWidth-1:0]  ticks;
  logic [7:0]            tick_eff;
  logic [DvdWidth-1:0]   dividend;
  logic [DivWidth-1:0]   divisor;
  logic                  out_free;
  logic                  frame_load;

  // Input side handshake
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;

  // Rounding operands, a zero tick length acts as 1 us
  assign tick_eff = (tick_q == 8'd0) ? 8'd1 : tick_q;
  assign dividend = {1'b0, period_us_i, 1'b0} + {10'd0, tick_eff};
  assign divisor  = {tick_eff, 1'b0};

  sfr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (ticks)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StDiv;
      end
      StDiv: begin
        if (div_done) state_d = last_q ? StFrame : StIdle;
      end
      StFrame: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    frame_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        div_start  = accept;
      end
      StDiv: ;
      StFrame: begin
        frame_load = out_free;
      end
      default: ;
    endcase
  end

  // Pulse checks and nibble capture, running data CRC
  logic [3:0]            nib;
  logic                  nib_ok;
  logic                  sync_ok;

  // Frame result and slow channel
  logic [2:0]            err;
  logic [3:0]            crc_fin;
  logic                  s2, s3;
  logic [17:0]           b2n, b3n;
  logic [23:0]           scn;
  logic [3:0]            c4;
  logic [5:0]            c6;
  logic                  short_hit, enh_hit;

  always_comb begin
    nib     = 4'(ticks - NibbleMin);
    nib_ok  = (ticks >= NibbleMin) && (ticks <= NibbleMax);
    sync_ok = (ticks >= SyncMin) && (ticks <= SyncMax);

    pidx_d   = pidx_q;
    ferr_d   = ferr_q;
    status_d = status_q;
    data_d   = data_q;
    crc_d    = crc_q;
    check_d  = check_q;
    b2_d     = b2_q;
    b3_d     = b3_q;
    sc_d     = sc_q;
    good_d   = good_q;
    bad_d    = bad_q;

    ovalid_d = ovalid_q && out_stall_i;
    oerr_d   = oerr_q;
    ostat_d  = ostat_q;
    odata_d  = odata_q;
    osv_d    = osv_q;
    ofmt_d   = ofmt_q;
    oid_d    = oid_q;
    osdat_d  = osdat_q;

    if (state_q == StDiv && div_done && pidx_q < PulseCount) begin
      if (ferr_q == ErrOk) begin
        if (pidx_q == PulseSync) begin
          if (!sync_ok) ferr_d = ErrSync;
        end else if (!nib_ok) begin
          ferr_d = ErrNibble;
        end else if (pidx_q == PulseStatus) begin
          status_d = nib;
        end else if (pidx_q <= PulseData5) begin
          data_d = {data_q[19:0], nib};
          crc_d  = nib ^ CRC4_TAB[(pidx_q == PulseData0) ? Crc4Seed : crc_q];
        end else begin
          check_d = nib;
        end
      end
      pidx_d = pidx_q + 4'd1;
    end

    // Frame error code
    crc_fin = CRC4_TAB[crc_q];
    if (pidx_q < PulseCount) begin
      err = ErrShort;
    end else if (ferr_q != ErrOk) begin
      err = ferr_q;
    end else if (crc_fin != check_q) begin
      err = ErrCrc;
    end else begin
      err = ErrOk;
    end

    // Slow channel registers after shifting in this status nibble
    s2  = status_q[2];
    s3  = status_q[3];
    b2n = {b2_q[16:0], s2};
    b3n = {b3_q[16:0], s3};
    scn = {sc_q[21:0], s2, s3};

    c4 = b2n[15:12] ^ CRC4_TAB[Crc4Seed];
    c4 = b2n[11:8] ^ CRC4_TAB[c4];
    c4 = b2n[7:4] ^ CRC4_TAB[c4];
    c4 = CRC4_TAB[c4];

    c6 = scn[23:18] ^ CRC6_TAB[Crc6Seed];
    c6 = scn[17:12] ^ CRC6_TAB[c6];
    c6 = scn[11:6] ^ CRC6_TAB[c6];
    c6 = scn[5:0] ^ CRC6_TAB[c6];
    c6 = CRC6_TAB[c6];

    short_hit = b3n[15:0] == ShortMark;
    enh_hit   = (b3n & EnhMask) == EnhMark;

    if (frame_load) begin
      pidx_d   = '0;
      ferr_d   = ErrOk;
      ovalid_d = 1'b1;
      oerr_d   = err;
      ostat_d  = '0;
      odata_d  = '0;
      osv_d    = 1'b0;
      ofmt_d   = FmtShort;
      oid_d    = '0;
      osdat_d  = '0;
      if (err != ErrOk) begin
        if (bad_q != '1) bad_d = bad_q + 1'b1;
        b3_d = '0;
      end else begin
        if (good_q != '1) good_d = good_q + 1'b1;
        ostat_d = status_q;
        odata_d = data_q;
        b2_d    = b2n;
        sc_d    = scn;
        b3_d    = b3n;
        if (short_hit) begin
          b3_d = '0;
          if (c4 == b2n[3:0]) begin
            osv_d   = 1'b1;
            ofmt_d  = FmtShort;
            oid_d   = {4'd0, b2n[15:12]};
            osdat_d = {8'd0, b2n[11:4]};
          end
        end else if (enh_hit && c6 == b2n[17:12]) begin
          b3_d  = '0;
          osv_d = 1'b1;
          if (b3n[10]) begin
            ofmt_d  = FmtEnh16;
            oid_d   = {4'd0, b3n[9:6]};
            osdat_d = {b3n[4:1], b2n[11:0]};
          end else begin
            ofmt_d  = FmtEnh12;
            oid_d   = {b3n[9:6], b3n[4:1]};
            osdat_d = {4'd0, b2n[11:0]};
          end
        end
      end
    end
  end

  // Control and slow channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tick_q   <= TickReset;
      pidx_q   <= '0;
      ferr_q   <= ErrOk;
      status_q <= '0;
      b2_q     <= '0;
      b3_q     <= '0;
      sc_q     <= '0;
      good_q   <= '0;
      bad_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) tick_q <= cfg_data_i;
      pidx_q   <= pidx_d;
      ferr_q   <= ferr_d;
      status_q <= status_d;
      b2_q     <= b2_d;
      b3_q     <= b3_d;
      sc_q     <= sc_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) last_q <= frame_last_i;
    data_q  <= data_d;
    crc_q   <= crc_d;
    check_q <= check_d;
    oerr_q  <= oerr_d;
    ostat_q <= ostat_d;
    odata_q <= odata_d;
    osv_q   <= osv_d;
    ofmt_q  <= ofmt_d;
    oid_q   <= oid_d;
    osdat_q <= osdat_d;
  end

  assign out_valid_o        = ovalid_q;
  assign frame_error_o      = oerr_q;
  assign status_nibble_o    = ostat_q;
  assign data_nibbles_o     = odata_q;
  assign serial_valid_o     = osv_q;
  assign serial_format_o    = ofmt_q;
  assign serial_id_o        = oid_q;
  assign serial_data_o      = osdat_q;
  assign good_frame_count_o = 32'(good_q);
  assign bad_frame_count_o  = 32'(bad_q);

endmodule

// ===== src/sfr_divider.sv =====
module sfr_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sfr_pkg::DvdWidth-1:0]  dividend_i,
  input  logic [sfr_pkg::DivWidth-1:0]  divisor_i,
  output logic                          done_o,
  output logic [sfr_pkg::QuotWidth-1:0] quot_o
);
  import sfr_pkg::*;

  // Remainder stays below the divisor, so one extra bit holds the trial value
  logic [DivWidth:0]    rem_q, rem_d;
  logic [QuotWidth-1:0] dvd_q, dvd_d;
  logic [DivWidth-1:0]  div_q, div_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivWidth:0]    trial;
  logic                 fits;

  // One restoring step per cycle; quotient bits shift in behind the dividend
  always_comb begin
    trial  = {rem_q[DivWidth-1:0], dvd_q[QuotWidth-1]};
    fits   = trial >= {1'b0, div_q};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // Top dividend bits are always below the divisor
      rem_d  = {{(DivWidth+1-(DvdWidth-QuotWidth)){1'b0}},
                dividend_i[DvdWidth-1:QuotWidth]};
      dvd_d  = dividend_i[QuotWidth-1:0];
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, div_q}) : trial;
      dvd_d = {dvd_q[QuotWidth-2:0], fits};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(QuotWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== tb/tb_sent_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

module tb_sent_frame_receiver_unit;
  import sfr_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 40;

  // Result of one frame, field order matches the output ports
  typedef struct packed {
    logic [2:0]  error;
    logic [3:0]  status;
    logic [23:0] data;
    logic        ser_valid;
    logic [1:0]  ser_fmt;
    logic [7:0]  ser_id;
    logic [15:0] ser_data;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
  } frame_result_t;

  typedef enum int unsigned {
    FrGood,
    FrBadCrc,
    FrBadNibble,
    FrBadSync,
    FrShort,
    FrExtra
  } frame_kind_e;

  // Frame decoder model plus the queue of frame results still owed by the block
  class frame_scoreboard;
    logic [7:0]    tick;
    logic [3:0]    pulse_idx;
    logic [2:0]    first_err;
    logic [3:0]    nib [7];
    logic [3:0]    status_hold;
    logic [17:0]   bit2_sr;
    logic [17:0]   bit3_sr;
    logic [23:0]   crc_sr;
    logic [31:0]   good_frames;
    logic [31:0]   bad_frames;
    frame_result_t expected_frames [$];
    int unsigned   errors;
    int unsigned   frames_seen;
    int unsigned   messages_seen;

    function new();
      tick        = TickReset;
      pulse_idx   = '0;
      first_err   = ErrOk;
      status_hold = '0;
      bit2_sr     = '0;
      bit3_sr     = '0;
      crc_sr      = '0;
      good_frames = '0;
      bad_frames  = '0;
      foreach (nib[i]) nib[i] = '0;
      errors        = 0;
      frames_seen   = 0;
      messages_seen = 0;
    endfunction

    // Table CRC4 over n nibbles, first nibble highest
    static function logic [3:0] crc4_calc(logic [23:0] nibs, int unsigned n);
      logic [3:0] c;
      c = Crc4Seed;
      for (int i = n - 1; i >= 0; i--) c = nibs[i*4 +: 4] ^ CRC4_TAB[c];
      return CRC4_TAB[c];
    endfunction

    // Table CRC6 over four 6-bit chunks plus one zero chunk
    static function logic [5:0] crc6_calc(logic [23:0] d);
      logic [5:0] c;
      c = Crc6Seed;
      c = d[23:18] ^ CRC6_TAB[c];
      c = d[17:12] ^ CRC6_TAB[c];
      c = d[11:6] ^ CRC6_TAB[c];
      c = d[5:0] ^ CRC6_TAB[c];
      return CRC6_TAB[c];
    endfunction

    // Slow channel: shift in status bits 2 and 3, look for a finished message
    function bit slow_step(logic [3:0] st, inout frame_result_t r);
      logic [3:0] n0, n1, n2;
      bit2_sr = {bit2_sr[16:0], st[2]};
      crc_sr  = {crc_sr[21:0], st[2], st[3]};
      bit3_sr = {bit3_sr[16:0], st[3]};
      if (bit3_sr[15:0] == ShortMark) begin
        bit3_sr = '0;
        n0 = bit2_sr[15:12];
        n1 = bit2_sr[11:8];
        n2 = bit2_sr[7:4];
        if (crc4_calc({n0, n1, n2}, 3) != bit2_sr[3:0]) return 1'b0;
        r.ser_fmt  = FmtShort;
        r.ser_id   = {4'd0, n0};
        r.ser_data = {8'd0, bit2_sr[11:4]};
        return 1'b1;
      end
      if ((bit3_sr & EnhMask) == EnhMark) begin
        // failed enhanced crc leaves the bit3 register alone
        if (crc6_calc(crc_sr) != bit2_sr[17:12]) return 1'b0;
        if (bit3_sr[10]) begin
          r.ser_fmt  = FmtEnh16;
          r.ser_id   = {4'd0, bit3_sr[9:6]};
          r.ser_data = {bit3_sr[4:1], bit2_sr[11:0]};
        end else begin
          r.ser_fmt  = FmtEnh12;
          r.ser_id   = {bit3_sr[9:6], bit3_sr[4:1]};
          r.ser_data = {4'd0, bit2_sr[11:0]};
        end
        bit3_sr = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // One accepted pulse item; frame_last closes the frame and owes a result
    function void note_pulse(logic [15:0] period, logic last);
      int unsigned   t, ticks, pw;
      logic [2:0]    err;
      logic [31:0]   cnt_max;
      frame_result_t r;
      t       = (tick == 0) ? 1 : tick;
      pw      = period;
      ticks   = (2 * pw + t) / (2 * t);
      cnt_max = 32'((64'd1 << CountWidth) - 1);
      if (pulse_idx < PulseCount) begin
        if (first_err == ErrOk) begin
          if (pulse_idx == PulseSync) begin
            if (ticks < 55 || ticks > 57) first_err = ErrSync;
          end else if (ticks < 12 || ticks > 27) begin
            first_err = ErrNibble;
          end else if (pulse_idx == PulseStatus) begin
            status_hold = 4'(ticks - 12);
          end else begin
            nib[pulse_idx - PulseData0] = 4'(ticks - 12);
          end
        end
        pulse_idx++;
      end
      if (!last) return;

      err = (pulse_idx < PulseCount) ? ErrShort : first_err;
      if (err == ErrOk &&
          crc4_calc({nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]}, 6) != nib[6])
        err = ErrCrc;
      pulse_idx = '0;
      first_err = ErrOk;

      r = '0;
      r.error = err;
      if (err != ErrOk) begin
        if (bad_frames < cnt_max) bad_frames++;
        bit3_sr = '0;
      end else begin
        r.status = status_hold;
        r.data   = {nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
        if (good_frames < cnt_max) good_frames++;
        r.ser_valid = slow_step(status_hold, r);
        if (!r.ser_valid) begin
          r.ser_fmt  = '0;
          r.ser_id   = '0;
          r.ser_data = '0;
        end
      end
      r.good_cnt = good_frames;
      r.bad_cnt  = bad_frames;
      expected_frames.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // One accepted result item against the oldest owed frame
    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual error %0d",
                 $time, got.error);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      frames_seen++;
      if (want.ser_valid) messages_seen++;
      compare_field("frame_error", want.error, got.error);
      compare_field("status_nibble", want.status, got.status);
      compare_field("data_nibbles", want.data, got.data);
      compare_field("serial_valid", want.ser_valid, got.ser_valid);
      compare_field("serial_format", want.ser_fmt, got.ser_fmt);
      compare_field("serial_id", want.ser_id, got.ser_id);
      compare_field("serial_data", want.ser_data, got.ser_data);
      compare_field("good_frame_count", want.good_cnt, got.good_cnt);
      compare_field("bad_frame_count", want.bad_cnt, got.bad_cnt);
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [7:0]  cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [15:0] period_us_i  = '0;
  logic        frame_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [2:0]  frame_error_o;
  logic [3:0]  status_nibble_o;
  logic [23:0] data_nibbles_o;
  logic        serial_valid_o;
  logic [1:0]  serial_format_o;
  logic [7:0]  serial_id_o;
  logic [15:0] serial_data_o;
  logic [31:0] good_frame_count_o;
  logic [31:0] bad_frame_count_o;

  frame_scoreboard sb;
  frame_result_t   got_frame;
  bit              idle_on = 1'b1;
  int unsigned     cur_tick = TickReset;
  int unsigned     pulses_sent = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_left = 0;

  always #6 clk_i = ~clk_i;

  sent_frame_receiver_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .period_us_i        (period_us_i),
    .frame_last_i       (frame_last_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_error_o      (frame_error_o),
    .status_nibble_o    (status_nibble_o),
    .data_nibbles_o     (data_nibbles_o),
    .serial_valid_o     (serial_valid_o),
    .serial_format_o    (serial_format_o),
    .serial_id_o        (serial_id_o),
    .serial_data_o      (serial_data_o),
    .good_frame_count_o (good_frame_count_o),
    .bad_frame_count_o  (bad_frame_count_o)
  );

  assign got_frame = {frame_error_o, status_nibble_o, data_nibbles_o, serial_valid_o,
                      serial_format_o, serial_id_o, serial_data_o,
                      good_frame_count_o, bad_frame_count_o};

  // Receiver stalls in bursts, started at random while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each accepted result item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_frame(got_frame);
  end

  // Count cycles without any progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
    $display("sent_frame_receiver_unit verification failed");
    $finish;
  end

  // Pulse period that rounds to the given tick count, jittered inside the window
  function automatic logic [15:0] period_of(int unsigned ticks);
    int unsigned t, lo, hi;
    t  = (cur_tick == 0) ? 1 : cur_tick;
    lo = ticks * t - t / 2;
    hi = ticks * t + (t - 1) / 2;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Drive one pulse item, with an occasional gap ahead of it
  task automatic send_pulse(logic [15:0] period, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    period_us_i  <= period;
    frame_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pulse(period, last);
    pulses_sent++;
  endtask

  // Wait until every owed result is in and the block has settled
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tick(logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tick  = value;
    cur_tick = value;
  endtask

  // One frame of sync, status, six data and crc pulses, optionally damaged
  task automatic send_frame(logic [3:0] status, logic [23:0] data, frame_kind_e kind);
    int unsigned tk [9];
    int unsigned npulse;
    logic [3:0]  crc;
    crc = frame_scoreboard::crc4_calc(data, 6);
    if (kind == FrBadCrc ||
        ((kind == FrExtra || kind == FrBadNibble) && $urandom_range(0, 1) == 1))
      crc = crc ^ 4'($urandom_range(1, 15));
    tk[0] = $urandom_range(55, 57);
    tk[1] = status + 12;
    for (int i = 0; i < 6; i++) tk[2 + i] = data[20 - 4 * i +: 4] + 12;
    tk[8] = crc + 12;
    npulse = 9;
    case (kind)
      FrBadSync: begin
        tk[0] = ($urandom_range(0, 1) == 1) ? 54 : 58;
        if ($urandom_range(0, 1) == 1) tk[$urandom_range(1, 8)] = 28;
      end
      FrBadNibble: tk[$urandom_range(1, 8)] = ($urandom_range(0, 1) == 1) ? 11 : 28;
      FrShort:     npulse = $urandom_range(1, 8);
      FrExtra:     npulse = $urandom_range(10, 12);
      default: ;
    endcase
    for (int i = 0; i < npulse; i++)
      send_pulse((i < 9) ? period_of(tk[i]) : 16'($urandom), i == npulse - 1);
  endtask

  // Random periods, extremes included
  task automatic send_noise();
    int unsigned n;
    logic [15:0] p;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       p = 16'h0000;
        1:       p = 16'hffff;
        default: p = 16'($urandom);
      endcase
      send_pulse(p, i == n - 1);
    end
  endtask

  // A whole slow-channel message carried in status bits 3 and 2 of good frames
  task automatic send_serial(logic [1:0] fmt, bit corrupt);
    logic [17:0] v2, v3;
    logic [11:0] d12;
    logic [23:0] mix;
    logic [3:0]  id4, a, b;
    logic [7:0]  d8;
    int unsigned nfr;
    if (fmt == FmtShort) begin
      id4 = 4'($urandom);
      d8  = 8'($urandom);
      v2  = {2'b00, id4, d8, frame_scoreboard::crc4_calc({id4, d8}, 3)};
      v3  = {2'b00, ShortMark};
      nfr = 16;
    end else begin
      a   = 4'($urandom);
      b   = 4'($urandom);
      d12 = 12'($urandom);
      // preamble of six ones, zero, format bit, then id and data with zero gaps
      v3  = {6'h3f, 1'b0, fmt == FmtEnh16, a, 1'b0, b, 1'b0};
      mix = '0;
      for (int i = 11; i >= 0; i--) mix = {mix[21:0], d12[i], v3[i]};
      v2  = {frame_scoreboard::crc6_calc(mix), d12};
      nfr = 18;
    end
    if (corrupt) v2[$urandom_range(0, nfr - 1)] ^= 1'b1;
    for (int i = nfr - 1; i >= 0; i--) begin
      // now and then a bad frame breaks the message
      if ($urandom_range(0, 39) == 0)
        send_frame(4'($urandom), 24'($urandom), frame_kind_e'($urandom_range(1, 4)));
      send_frame({v3[i], v2[i], 2'($urandom)}, 24'($urandom), FrGood);
    end
  endtask

  initial begin : stimulus
    int unsigned rand_base, cfg_step, pick, last_tick;
    logic [2:0]  fmt_sent;
    logic [1:0]  fmt;
    sb        = new();
    fmt_sent  = '0;
    cfg_step  = 0;
    last_tick = TickReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme nibbles, short frame over a bad sync, extra pulses
    send_frame(4'hf, 24'h0f00ff, FrGood);
    send_pulse(16'h0000, 1'b0);
    send_pulse(16'hffff, 1'b1);
    send_frame(4'h0, 24'hffffff, FrExtra);
    send_pulse(16'hffff, 1'b1);

    // Random: mostly serial messages, the rest single frames, good or damaged, and noise
    rand_base = pulses_sent;
    while (pulses_sent - rand_base < 500) begin
      if (cfg_step < 4 && pulses_sent - rand_base >= cfg_step * 110) begin
        drain_results();
        case (cfg_step)
          0:       last_tick = 1;
          1:       last_tick = 255;
          2:       last_tick = 0;
          default: last_tick = $urandom_range(2, 254);
        endcase
        write_tick(8'(last_tick));
        cfg_step++;
      end
      if (pulses_sent - rand_base >= 430) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // formats not yet seen go first
        if (!fmt_sent[FmtShort])     fmt = FmtShort;
        else if (!fmt_sent[FmtEnh12]) fmt = FmtEnh12;
        else if (!fmt_sent[FmtEnh16]) fmt = FmtEnh16;
        else                          fmt = 2'(pick % 3);
        if ($urandom_range(0, 7) == 0) begin
          send_serial(fmt, 1'b1);
        end else begin
          send_serial(fmt, 1'b0);
          fmt_sent[fmt] = 1'b1;
        end
      end else if (pick < 9) begin
        send_frame(4'($urandom), 24'($urandom), frame_kind_e'($urandom_range(0, 5)));
      end else begin
        send_noise();
      end
    end

    drain_results();
    $display("Run covered %0d pulse items and %0d frames: %0d good, %0d rejected,",
             pulses_sent, sb.frames_seen, sb.good_frames, sb.bad_frames);
    $display("with %0d slow-channel messages, tick lengths 3, 1, 255, 0 and %0d us.",
             sb.messages_seen, last_tick);
    if (sb.errors == 0) begin
      $display("sent_frame_receiver_unit verification clean");
    end else begin
      $display("sent_frame_receiver_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sfr_pkg.sv
src/sfr_divider.sv
src/sent_frame_receiver_unit.sv
tb/tb_sent_frame_receiver_unit.sv
